// File: rtl/running_median_two_heaps_core_assert.svh
// assertion macros shared by the running median checker
// depends on a clk and rst_n signal in the scope of use
`ifndef RUNNING_MEDIAN_TWO_HEAPS_CORE_ASSERT_SVH
`define RUNNING_MEDIAN_TWO_HEAPS_CORE_ASSERT_SVH

// same-cycle implication under reset
`define RMTH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under reset
`define RMTH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/rmth_pkg.sv
// shared types and constants for the running median core
// no dependencies
package rmth_pkg;

  localparam int COUNT_W = 11;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SD_RD,
    ST_SD_CMP,
    ST_SU_INIT,
    ST_SU_RD,
    ST_SU_CMP,
    ST_FIN
  } rmth_state_t;

endpackage

// File: rtl/rmth_heap_ram.sv
// heap storage: one write port, two registered read ports
// no package dependencies
module rmth_heap_ram #(
  parameter int DW    = 32,
  parameter int DEPTH = 513,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr_a,
  input  logic [AW-1:0] rd_addr_b,
  output logic [DW-1:0] rd_data_a,
  output logic [DW-1:0] rd_data_b
);

  logic [DW-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read ports, registered
  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

// File: rtl/running_median_two_heaps_core.sv
// Throughput: one word at a time; the next word is taken once the previous
// result sits in the output register. Level walks run over the heap RAM read ports.
// Reset: synchronous active low, empties both heaps; heap RAM contents
// are not cleared, only entries below the heap size are ever used.
// top level of the running median core; uses rmth_pkg and rmth_heap_ram
module running_median_two_heaps_core
  import rmth_pkg::*;
#(
  parameter int CAPACITY   = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          in_tvalid,
  output logic                                          in_tready,
  input  logic [((DATA_WIDTH + 7) / 8) * 8 - 1:0]           in_tdata,   // sample
  output logic                                          out_tvalid,
  input  logic                                          out_tready,
  output logic [((DATA_WIDTH + COUNT_W + 7) / 8) * 8 - 1:0] out_tdata,  // median, count, zero pad
  output logic                                          out_tuser   // dropped
);

  localparam int OUT_TW = ((DATA_WIDTH + COUNT_W + 7) / 8) * 8;
  localparam int HALF   = CAPACITY / 2 + 1;
  localparam int AW     = $clog2(HALF);
  localparam int SW     = $clog2(CAPACITY + 3);

  rmth_state_t state_r, state_nxt;

  logic signed [DATA_WIDTH-1:0] val_r, val_nxt;     // value being placed
  logic signed [DATA_WIDTH-1:0] pv_r, pv_nxt;       // value to push
  logic signed [DATA_WIDTH-1:0] top_lo_r, top_lo_nxt;
  logic signed [DATA_WIDTH-1:0] top_up_r, top_up_nxt;
  logic [SW-1:0]                idx_r, idx_nxt;
  logic [SW-1:0]                lsize_r, lsize_nxt;
  logic [SW-1:0]                usize_r, usize_nxt;
  logic                         push_up_r, push_up_nxt;
  logic                         drop_r, drop_nxt;

  logic signed [DATA_WIDTH-1:0] median_r;
  logic [COUNT_W-1:0]           count_r;
  logic                         out_drop_r;
  logic                         out_valid_r;

  // ram buses
  logic                  wr_en;
  logic                  wr_up;
  logic [AW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [AW-1:0]         rd_addr_a, rd_addr_b;
  logic [DATA_WIDTH-1:0] lo_rd_a, lo_rd_b, up_rd_a, up_rd_b;

  // working signals
  logic                         in_acc;
  logic signed [DATA_WIDTH-1:0] smp;
  logic [SW-1:0]                total;
  logic                         cur_up;
  logic                         is_max;
  logic signed [DATA_WIDTH-1:0] rd_a, rd_b;
  logic [SW-1:0]                lidx, ridx, pidx, cur_size, best_idx;
  logic signed [DATA_WIDTH-1:0] best_val;
  logic                         r_better, best_beats, v_beats;
  logic                         fin_go;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign smp       = in_tdata[DATA_WIDTH-1:0];
  assign total     = lsize_r + usize_r;
  assign fin_go    = !out_valid_r || out_tready;

  // heap under work: sift-down phases act on the heap opposite to the push
  assign cur_up   = (state_r == ST_SD_RD || state_r == ST_SD_CMP) ? !push_up_r : push_up_r;
  assign is_max   = !cur_up;
  assign cur_size = cur_up ? usize_r : lsize_r;
  assign rd_a     = cur_up ? up_rd_a : lo_rd_a;
  assign rd_b     = cur_up ? up_rd_b : lo_rd_b;

  // child and parent indices
  assign lidx = {idx_r[SW-2:0], 1'b1};
  assign ridx = lidx + SW'(1);
  assign pidx = (idx_r - SW'(1)) >> 1;

  // child selection and ordering tests
  assign r_better   = (ridx < cur_size) && (is_max ? (rd_b > rd_a) : (rd_b < rd_a));
  assign best_idx   = r_better ? ridx : lidx;
  assign best_val   = r_better ? rd_b : rd_a;
  assign best_beats = is_max ? (best_val > val_r) : (best_val < val_r);
  assign v_beats    = is_max ? (val_r > rd_a) : (val_r < rd_a);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (total >= SW'(CAPACITY)) begin
            state_nxt = ST_FIN;
          end else if (!total[0]) begin
            state_nxt = (lsize_r != '0 && smp < top_lo_r) ? ST_SD_RD : ST_SU_INIT;
          end else begin
            state_nxt = (usize_r != '0 && smp > top_up_r) ? ST_SD_RD : ST_SU_INIT;
          end
        end
      end
      ST_SD_RD:   state_nxt = (lidx >= cur_size) ? ST_SU_INIT : ST_SD_CMP;
      ST_SD_CMP:  state_nxt = best_beats ? ST_SD_RD : ST_SU_INIT;
      ST_SU_INIT: state_nxt = ST_SU_RD;
      ST_SU_RD:   state_nxt = (idx_r == '0) ? ST_FIN : ST_SU_CMP;
      ST_SU_CMP:  state_nxt = v_beats ? ST_SU_RD : ST_FIN;
      ST_FIN:     state_nxt = fin_go ? ST_IDLE : ST_FIN;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    val_nxt     = val_r;
    pv_nxt      = pv_r;
    idx_nxt     = idx_r;
    lsize_nxt   = lsize_r;
    usize_nxt   = usize_r;
    push_up_nxt = push_up_r;
    drop_nxt    = drop_r;
    wr_en       = 1'b0;
    wr_up       = cur_up;
    wr_addr     = idx_r[AW-1:0];
    wr_data     = val_r;
    rd_addr_a   = lidx[AW-1:0];
    rd_addr_b   = ridx[AW-1:0];
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          drop_nxt    = (total >= SW'(CAPACITY));
          push_up_nxt = !total[0];
          val_nxt     = smp;
          pv_nxt      = smp;
          idx_nxt     = '0;
          if (!total[0] && lsize_r != '0 && smp < top_lo_r) begin
            pv_nxt = top_lo_r;
          end
          if (total[0] && usize_r != '0 && smp > top_up_r) begin
            pv_nxt = top_up_r;
          end
        end
      end
      ST_SD_RD: begin
        if (lidx >= cur_size) begin
          wr_en = 1'b1;
        end
      end
      ST_SD_CMP: begin
        wr_en = 1'b1;
        if (best_beats) begin
          wr_data = best_val;
          idx_nxt = best_idx;
        end
      end
      ST_SU_INIT: begin
        val_nxt = pv_r;
        if (push_up_r) begin
          idx_nxt   = usize_r;
          usize_nxt = usize_r + SW'(1);
        end else begin
          idx_nxt   = lsize_r;
          lsize_nxt = lsize_r + SW'(1);
        end
      end
      ST_SU_RD: begin
        rd_addr_a = pidx[AW-1:0];
        if (idx_r == '0) begin
          wr_en = 1'b1;
        end
      end
      ST_SU_CMP: begin
        wr_en = 1'b1;
        if (v_beats) begin
          wr_data = rd_a;
          idx_nxt = pidx;
        end
      end
      ST_FIN: begin
      end
      default: begin
      end
    endcase
  end

  // heap tops mirror entry zero of each ram
  always_comb begin
    top_lo_nxt = top_lo_r;
    top_up_nxt = top_up_r;
    if (wr_en && wr_addr == '0) begin
      if (wr_up) begin
        top_up_nxt = wr_data;
      end else begin
        top_lo_nxt = wr_data;
      end
    end
  end

  // median of the settled store
  logic signed [DATA_WIDTH:0]   pair_sum;
  logic signed [DATA_WIDTH-1:0] median_nxt;
  assign pair_sum   = {top_lo_r[DATA_WIDTH-1], top_lo_r} + {top_up_r[DATA_WIDTH-1], top_up_r};
  assign median_nxt = (total[0] || lsize_r == '0) ? top_up_r : pair_sum[DATA_WIDTH:1];

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lsize_r     <= '0;
      usize_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      lsize_r <= lsize_nxt;
      usize_r <= usize_nxt;
      if (state_r == ST_FIN && fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    val_r     <= val_nxt;
    pv_r      <= pv_nxt;
    idx_r     <= idx_nxt;
    push_up_r <= push_up_nxt;
    drop_r    <= drop_nxt;
    top_lo_r  <= top_lo_nxt;
    top_up_r  <= top_up_nxt;
    if (state_r == ST_FIN && fin_go) begin
      median_r   <= median_nxt;
      count_r    <= COUNT_W'(total);
      out_drop_r <= drop_r;
    end
  end

  // heap memories
  rmth_heap_ram #(.DW(DATA_WIDTH), .DEPTH(HALF), .AW(AW)) u_lo_ram (
    .clk       (clk),
    .wr_en     (wr_en && !wr_up),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (lo_rd_a),
    .rd_data_b (lo_rd_b)
  );

  rmth_heap_ram #(.DW(DATA_WIDTH), .DEPTH(HALF), .AW(AW)) u_up_ram (
    .clk       (clk),
    .wr_en     (wr_en && wr_up),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (up_rd_a),
    .rd_data_b (up_rd_b)
  );

  // result word
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TW'({count_r, median_r});
  assign out_tuser  = out_drop_r;

endmodule

// File: rtl/rmth_checker.sv
// port-level checks for the running median core, bound to the top level
// uses rmth_pkg and running_median_two_heaps_core_assert.svh
`include "running_median_two_heaps_core_assert.svh"

module rmth_checker
  import rmth_pkg::*;
#(
  parameter int CAPACITY   = 1024,
  parameter int DATA_WIDTH = 32
) (
  input logic                                          clk,
  input logic                                          rst_n,
  input logic                                          in_tvalid,
  input logic                                          in_tready,
  input logic                                          out_tvalid,
  input logic                                          out_tready,
  input logic [((DATA_WIDTH + COUNT_W + 7) / 8) * 8 - 1:0] out_tdata,
  input logic                                          out_tuser
);

  logic [COUNT_W-1:0] count;
  assign count = out_tdata[DATA_WIDTH +: COUNT_W];

  // a stalled word holds
  `RMTH_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled output word changed")
  // every result holds at least one sample
  `RMTH_ASSERT_NOW(a_count_nz, out_tvalid, count != '0, "result count is zero")
  // a drop only happens on a full store
  `RMTH_ASSERT_NOW(a_drop_full, out_tvalid && out_tuser, count == COUNT_W'(CAPACITY), "drop flagged below capacity")
  // no input taken in the cycle after one was taken
  `RMTH_ASSERT_NEXT(a_one_at_time, in_tvalid && in_tready, !in_tready, "input taken back to back")

endmodule

bind running_median_two_heaps_core rmth_checker #(
  .CAPACITY   (CAPACITY),
  .DATA_WIDTH (DATA_WIDTH)
) u_rmth_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
